@@ rtl/core/q20rr_pkg.sv @@
// ----------------------------------------------------------------------------
// q20rr_pkg: shared types and constants of the Q20 rounded ratio unit
// Holds the record passed from the front part to the divider pipeline,
// the saturation codes and the default parameter values.
// ----------------------------------------------------------------------------
package q20rr_pkg;

  // Default number of fraction bits of the result
  localparam int FRAC_BITS_DEF = 20;
  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Operand and result widths
  localparam int OPND_W = 64;
  localparam int RES_W = 32;
  // Quotient bits computed once saturation is ruled out
  localparam int QUOT_BITS = RES_W - 1;

  // Saturation values of the signed result
  localparam logic [RES_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] NEG_MIN = 32'h8000_0000;

  // Operand mode carried on tuser
  typedef enum logic {
    MODE_UNSIGNED = 1'b0,
    MODE_SIGNED   = 1'b1
  } mode_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic              neg;   // numerator negative (signed mode only)
    logic              ovf;   // rounding sum does not fit 64 bits
    logic              zero;  // signed with non-positive divisor: result 0
    logic [OPND_W-1:0] sum;   // magnitude * 2^F + divisor / 2
    logic [OPND_W-1:0] den;   // effective divisor
  } rq_entry_t;

endpackage

@@ rtl/core/q20rr_front.sv @@
// ----------------------------------------------------------------------------
// q20rr_front: input stage of the Q20 rounded ratio unit
// Takes items from the input stream, forms the magnitude, the effective
// divisor and the rounding sum, and flags the special cases, in two stages.
// ----------------------------------------------------------------------------
module q20rr_front #(
  parameter int FracBits = q20rr_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic                           mode_i,
  input  logic [q20rr_pkg::OPND_W-1:0]   num_i,
  input  logic [q20rr_pkg::OPND_W-1:0]   den_i,
  input  logic                           full_i,
  output logic                           push_o,
  output q20rr_pkg::rq_entry_t           entry_o
);

  localparam int OpW  = q20rr_pkg::OPND_W;
  localparam int SumW = OpW + FracBits + 1;

  logic              en;
  logic              take;
  logic              is_signed;
  logic              den_zero;
  logic              neg_w;
  logic [OpW-1:0]    mag_w;
  logic [OpW-1:0]    den_w;

  logic              f1_vld_q;
  logic              f1_neg_q;
  logic              f1_zero_q;
  logic [OpW-1:0]    f1_mag_q;
  logic [OpW-1:0]    f1_den_q;

  logic [SumW-1:0]   sum_w;
  logic              f2_vld_q;
  q20rr_pkg::rq_entry_t f2_q;

  // Advance both stages unless the queue refuses the oldest item
  assign en         = !(f2_vld_q && full_i);
  assign s_tready_o = en;
  assign take       = s_tvalid_i && en;

  // Classify operands and take the magnitude
  assign is_signed = (mode_i == q20rr_pkg::MODE_SIGNED);
  assign den_zero  = (den_i == '0);
  assign neg_w     = is_signed && num_i[OpW-1];
  assign mag_w     = neg_w ? (~num_i + OpW'(1)) : num_i;
  assign den_w     = (!is_signed && den_zero) ? OpW'(1) : den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= take;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_neg_q  <= neg_w;
      f1_zero_q <= is_signed && (den_zero || den_i[OpW-1]);
      f1_mag_q  <= mag_w;
      f1_den_q  <= den_w;
    end
  end

  // Form magnitude * 2^F + divisor / 2 and detect overflow past 64 bits
  assign sum_w = {1'b0, f1_mag_q, {FracBits{1'b0}}} + SumW'(f1_den_q >> 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_q.neg  <= f1_neg_q;
      f2_q.zero <= f1_zero_q;
      f2_q.ovf  <= |sum_w[SumW-1:OpW];
      f2_q.sum  <= sum_w[OpW-1:0];
      f2_q.den  <= f1_den_q;
    end
  end

  assign push_o  = f2_vld_q && !full_i;
  assign entry_o = f2_q;

endmodule

@@ rtl/core/q20rr_queue.sv @@
// ----------------------------------------------------------------------------
// q20rr_queue: short queue between front and back
// Holds classified items so that the front and the divider stall apart.
// ----------------------------------------------------------------------------
module q20rr_queue #(
  parameter int Depth = q20rr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  q20rr_pkg::rq_entry_t wdata_i,
  input  logic                 pop_i,
  output q20rr_pkg::rq_entry_t rdata_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q20rr_pkg::rq_entry_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW-1:0] rd_ptr_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming transfer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill level beyond depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

@@ rtl/core/q20rr_back.sv @@
// ----------------------------------------------------------------------------
// q20rr_back: divider pipeline and result stage
// Checks saturation, then derives 31 quotient bits in a restoring divider,
// one bit per stage, applies sign and saturation and holds the result.
// ----------------------------------------------------------------------------
module q20rr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  q20rr_pkg::rq_entry_t          entry_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [q20rr_pkg::RES_W-1:0]   m_tdata_o
);

  localparam int OpW   = q20rr_pkg::OPND_W;
  localparam int ResW  = q20rr_pkg::RES_W;
  localparam int Steps = q20rr_pkg::QUOT_BITS;

  logic            en;
  logic [Steps:0]  vld_q;
  logic [OpW-1:0]  rem_q [Steps+1];
  logic [OpW-1:0]  den_q [Steps+1];
  logic [Steps-1:0] low_q [Steps+1];
  logic [Steps-1:0] quo_q [Steps+1];
  logic [Steps:0]  neg_q;
  logic [Steps:0]  sat_q;
  logic [Steps:0]  zero_q;

  logic [OpW-1:0]  top_w;
  logic [ResW-1:0] res_w;
  logic            out_vld_q;
  logic [ResW-1:0] out_data_q;

  // Advance the whole pipeline while the result register can move
  assign en    = !out_vld_q || m_tready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Steps-1:0], pop_o};
      out_vld_q <= vld_q[Steps];
    end
  end

  // Load stage: saturate when the quotient reaches 2^31
  assign top_w = {{Steps{1'b0}}, entry_i.sum[OpW-1:Steps]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= top_w;
      den_q[0]  <= entry_i.den;
      low_q[0]  <= entry_i.sum[Steps-1:0];
      quo_q[0]  <= '0;
      neg_q[0]  <= entry_i.neg;
      zero_q[0] <= entry_i.zero;
      sat_q[0]  <= entry_i.ovf || (top_w >= entry_i.den);
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [OpW:0]   part;
    logic [OpW+1:0] diff;
    logic           ge;

    assign part = {rem_q[i], low_q[i][Steps-1]};
    assign diff = {1'b0, part} - {2'b00, den_q[i]};
    assign ge   = !diff[OpW+1];

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[i+1]  <= ge ? diff[OpW-1:0] : part[OpW-1:0];
        den_q[i+1]  <= den_q[i];
        low_q[i+1]  <= {low_q[i][Steps-2:0], 1'b0};
        quo_q[i+1]  <= {quo_q[i][Steps-2:0], ge};
        neg_q[i+1]  <= neg_q[i];
        sat_q[i+1]  <= sat_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // Apply special cases, saturation and sign
  always_comb begin
    if (zero_q[Steps]) begin
      res_w = '0;
    end else if (sat_q[Steps]) begin
      res_w = neg_q[Steps] ? q20rr_pkg::NEG_MIN : q20rr_pkg::POS_MAX;
    end else if (neg_q[Steps]) begin
      res_w = ResW'(0) - {1'b0, quo_q[Steps]};
    end else begin
      res_w = {1'b0, quo_q[Steps]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= res_w;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Steps] && !en) |=> vld_q[Steps])
    else $error("last divider stage lost an item while stalled");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Steps] && zero_q[Steps] && en) |=> (m_tvalid_o && m_tdata_o == '0))
    else $error("non-positive divisor did not give zero");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Steps] && sat_q[Steps] && !neg_q[Steps] && !zero_q[Steps] && en)
      |=> (m_tdata_o == q20rr_pkg::POS_MAX))
    else $error("positive saturation value wrong");

endmodule

@@ rtl/core/q20_rounded_ratio_unit.sv @@
// ----------------------------------------------------------------------------
// q20_rounded_ratio_unit: rounded, saturating fixed-point divider
// Returns numerator / denominator scaled by 2^FRAC_BITS, rounded half up
// on the magnitude and saturated to a signed 32-bit value.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output is not stalled and
// returns one result per item, in order. From input transfer to result an
// item passes, when the queue is empty, two front stages, one queue slot,
// a saturation check stage, 31 divider stages and the result register. The
// 31-stage restoring divider, one quotient bit per stage, is most of that path.
// Items are independent; no state is kept between them.
module q20_rounded_ratio_unit #(
  parameter int FRAC_BITS   = q20rr_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = q20rr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [127:0] s_tdata_i,   // [63:0] numerator, [127:64] denominator
  input  logic [0:0]   s_tuser_i,   // [0] mode
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [31:0]  m_tdata_o    // [31:0] ratio_q20
);

  localparam int OpW = q20rr_pkg::OPND_W;

  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  q20rr_pkg::rq_entry_t wr_entry;
  q20rr_pkg::rq_entry_t rd_entry;

  // Accept and classify input transfers
  q20rr_front #(
    .FracBits (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .mode_i     (s_tuser_i[0]),
    .num_i      (s_tdata_i[OpW-1:0]),
    .den_i      (s_tdata_i[2*OpW-1:OpW]),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  // Decouple front and divider
  q20rr_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // Divide, saturate and deliver results
  q20rr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .entry_i    (rd_entry),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule
